@@ rtl/lcfp_pkg.sv @@
// ----------------------------------------------------------------------------
// lcfp_pkg
// Shared types and constants for the link command frame parser.
// ----------------------------------------------------------------------------
package lcfp_pkg;

  // Input word kinds
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_JOIN  = 2'd1;
  localparam logic [1:0] OP_LEAVE = 2'd2;

  // Result event codes
  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_COMMAND      = 3'd1,
    EV_BLANK        = 3'd2,
    EV_HOST_ARRIVED = 3'd3,
    EV_REANNOUNCE   = 3'd4,
    EV_HOST_GONE    = 3'd5,
    EV_JOINED       = 3'd6,
    EV_LEFT         = 3'd7
  } event_t;

  // Frame progress, one-hot
  typedef enum logic [11:0] {
    FS_IDLE    = 12'b0000_0000_0001,
    FS_CMD_HDR = 12'b0000_0000_0010,  // C or X seen
    FS_CMD_Z   = 12'b0000_0000_0100,  // Z seen
    FS_CMD_ADR = 12'b0000_0000_1000,  // own address seen
    FS_BLK_HDR = 12'b0000_0001_0000,  // D seen
    FS_BLK_Z   = 12'b0000_0010_0000,
    FS_BLK_ADR = 12'b0000_0100_0000,
    FS_HST_HDR = 12'b0000_1000_0000,  // M seen
    FS_HST_D0  = 12'b0001_0000_0000,  // M 0 seen
    FS_GON_HDR = 12'b0010_0000_0000,  // E seen
    FS_GON_ADR = 12'b0100_0000_0000,
    FS_GON_D0  = 12'b1000_0000_0000
  } frame_state_t;

  typedef struct packed {
    frame_state_t frame;
    logic         x_marker;
    logic         link_en;
    logic         host_mode;
    logic         blanked;
    logic [3:0]   last_cmd;
    logic         xlate;
    logic [7:0]   seen;
  } parse_state_t;

  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_X    = 8'h58;
  localparam logic [7:0] CH_Z    = 8'h5A;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;
  localparam logic [7:0] SEEN_MAX = 8'd254;

endpackage

@@ rtl/lcfp_step.sv @@
// ----------------------------------------------------------------------------
// lcfp_step
// Next-state and event logic for one received word.
// ----------------------------------------------------------------------------
module lcfp_step
  import lcfp_pkg::*;
(
  input  parse_state_t st,
  input  logic [1:0]   op,
  input  logic [7:0]   rx_byte,
  input  logic [3:0]   node_address,
  output parse_state_t st_next,
  output event_t       event_res
);

  always_comb begin
    parse_state_t n;
    frame_state_t s;
    event_t       ev;
    logic         on;
    logic [7:0]   own;
    logic [7:0]   cnt;
    logic         digit;

    n     = st;
    s     = st.frame;
    ev    = EV_NONE;
    on    = st.link_en;
    own   = {4'd0, node_address} + CH_ZERO;
    cnt   = st.seen + 8'd1;
    digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

    unique case (op)
      OP_BYTE: begin
        // Tests run in fixed order on the updated frame state
        if (s == FS_IDLE && on) begin
          if (rx_byte == CH_C || rx_byte == CH_X) s = FS_CMD_HDR;
          n.x_marker = (rx_byte == CH_X);
        end
        if (s == FS_CMD_HDR && on && rx_byte == CH_Z) s = FS_CMD_Z;
        if (s == FS_CMD_ADR && on && digit) begin
          n.last_cmd = rx_byte[3:0] - CH_ZERO[3:0];
          n.blanked  = 1'b0;
          n.seen     = (cnt > SEEN_MAX) ? 8'd1 : cnt;
          n.xlate    = n.x_marker;
          ev         = EV_COMMAND;
        end
        if (s == FS_CMD_Z && on && rx_byte == own) s = FS_CMD_ADR;
        if (s == FS_IDLE && on && rx_byte == CH_D) s = FS_BLK_HDR;
        if (s == FS_BLK_HDR && on && rx_byte == CH_Z) s = FS_BLK_Z;
        if (s == FS_BLK_ADR && on && rx_byte == CH_ZERO) begin
          n.blanked = 1'b1;
          s         = FS_IDLE;
          ev        = EV_BLANK;
        end
        if (s == FS_BLK_Z && on && rx_byte == own) s = FS_BLK_ADR;
        if (rx_byte == CH_M) s = FS_HST_HDR;
        if (s == FS_HST_D0 && rx_byte == CH_ZERO) begin
          if (!st.host_mode) begin
            n.host_mode = 1'b1;
            ev          = EV_HOST_ARRIVED;
          end else begin
            n.link_en = 1'b1;
            ev        = EV_REANNOUNCE;
          end
          s = FS_IDLE;
        end
        if (s == FS_HST_HDR && rx_byte == CH_ZERO) s = FS_HST_D0;
        on = n.link_en;
        if (s == FS_IDLE && on && rx_byte == CH_E) s = FS_GON_HDR;
        if (s == FS_GON_D0 && on && rx_byte == CH_ZERO) begin
          n.host_mode = 1'b0;
          n.seen      = 8'd0;
          s           = FS_IDLE;
          ev          = EV_HOST_GONE;
        end
        if (s == FS_GON_ADR && on && rx_byte == CH_ZERO) s = FS_GON_D0;
        if (s == FS_GON_HDR && on && rx_byte == own) s = FS_GON_ADR;
        // No progress: drop back to idle
        if (s == st.frame) s = FS_IDLE;
        n.frame = s;
      end
      OP_JOIN: begin
        n.link_en = 1'b1;
        ev        = EV_JOINED;
      end
      OP_LEAVE: begin
        n.link_en = 1'b0;
        ev        = EV_LEFT;
      end
      default: begin
        ev = EV_NONE;
      end
    endcase

    st_next   = n;
    event_res = ev;
  end

endmodule

@@ rtl/link_command_frame_parser.sv @@
// ----------------------------------------------------------------------------
// link_command_frame_parser
// Receive-side frame parser for a slave node on a serial link.
// ----------------------------------------------------------------------------
// Path: an accepted input word goes to the input register, then its result
// word to the result register. Throughput: one word per cycle while the
// result stage is not stalled; the parser state updates in one pass.
// Reset (rst, synchronous): parser idle, link off, counters cleared,
// node_address = 1, both pipeline stages empty.
module link_command_frame_parser
  import lcfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,       // node_address
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [3:0] command_value, [4] translate,
                                      // [12:5] host_seen_count, [15:13] zero
  output logic [2:0]  m_axis_tuser    // [2:0] event_res
);

  logic [3:0]   node_address;
  parse_state_t st;
  parse_state_t st_next;
  event_t       ev;

  logic         in_valid;
  logic [1:0]   in_op;
  logic [7:0]   in_byte;

  logic         out_valid;
  logic [2:0]   out_event;
  logic [3:0]   out_cmd;
  logic         out_xlate;
  logic [7:0]   out_seen;

  logic         out_load;
  logic         in_load;

  assign cfg_ready     = 1'b1;
  assign out_load      = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      node_address <= cfg_data;
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= 1'b1;
    end else if (out_load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_op   <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  lcfp_step u_step (
    .st           (st),
    .op           (in_op),
    .rx_byte      (in_byte),
    .node_address (node_address),
    .st_next      (st_next),
    .event_res    (ev)
  );

  // Parser state advances as a word moves into the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{frame: FS_IDLE, x_marker: 1'b0, link_en: 1'b0, host_mode: 1'b0,
              blanked: 1'b0, last_cmd: 4'd0, xlate: 1'b0, seen: 8'd0};
    end else if (out_load) begin
      st <= st_next;
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_event <= ev;
      out_cmd   <= st_next.last_cmd;
      out_xlate <= st_next.xlate;
      out_seen  <= st_next.seen;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_event;
  assign m_axis_tdata  = {3'd0, out_seen, out_xlate, out_cmd};

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test for the link command frame parser. A queue of words (directed
// frames, then random frames and noise) feeds a handshaking driver. Each
// accepted word runs through a local copy of the parser, and the result word
// it predicts is matched field by field against the output stream. Both sides
// idle at random, and the node address changes between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import lcfp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Frame progress of the local parser copy
  typedef enum logic [3:0] {
    PS_IDLE, PS_CMD_HDR, PS_CMD_Z, PS_CMD_ADR, PS_BLK_HDR, PS_BLK_Z, PS_BLK_ADR,
    PS_HST_HDR, PS_HST_D0, PS_GON_HDR, PS_GON_ADR, PS_GON_D0
  } walk_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx;
  } link_word_t;

  typedef struct packed {
    event_t     ev;
    logic [3:0] cmd;
    logic       xlate;
    logic [7:0] seen;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = 4'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] rx_byte
  logic [1:0]  s_axis_tuser = 2'd0;   // [1:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // [3:0] command_value, [4] translate,
                                      // [12:5] host_seen_count
  logic [2:0]  m_axis_tuser;          // [2:0] event_res

  link_word_t    pending_words [$];
  parse_result_t results_due [$];
  int            n_queued = 0;
  int            n_accepted = 0;
  int            n_errors = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  // Local parser state
  logic [3:0] node_addr = 4'd1;
  walk_t      pr_frame = PS_IDLE;
  logic       pr_xmark = 1'b0;
  logic       pr_link = 1'b0;
  logic       pr_host = 1'b0;
  logic       pr_blank = 1'b0;
  logic [3:0] pr_cmd = 4'd0;
  logic       pr_xlate = 1'b0;
  logic [7:0] pr_seen = 8'd0;

  int unsigned phase_addr [8] = '{9, 0, 15, 1, 10, 4, 7, 9};

  link_command_frame_parser u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Tests run in a fixed chain against the frame state as it updates
  function automatic parse_result_t parse_word(input logic [1:0] op, input logic [7:0] c);
    parse_result_t r;
    walk_t         s;
    walk_t         prev;
    logic          on;
    logic [7:0]    own;
    logic [7:0]    n;
    logic [7:0]    digit;
    event_t        ev;
    ev = EV_NONE;
    own = {4'd0, node_addr} + CH_ZERO;
    case (op)
      OP_BYTE: begin
        s = pr_frame;
        prev = s;
        on = pr_link;
        if (s == PS_IDLE && on) begin
          if (c == CH_C || c == CH_X) s = PS_CMD_HDR;
          pr_xmark = (c == CH_X);
        end
        if (s == PS_CMD_HDR && on && c == CH_Z) s = PS_CMD_Z;
        if (s == PS_CMD_ADR && on && c >= CH_ZERO && c <= CH_NINE) begin
          digit = c - CH_ZERO;
          pr_cmd = digit[3:0];
          pr_blank = 1'b0;
          n = pr_seen + 8'd1;
          if (n > SEEN_MAX) n = 8'd1;
          pr_seen = n;
          pr_xlate = pr_xmark;
          ev = EV_COMMAND;
        end
        if (s == PS_CMD_Z && on && c == own) s = PS_CMD_ADR;
        if (s == PS_IDLE && on && c == CH_D) s = PS_BLK_HDR;
        if (s == PS_BLK_HDR && on && c == CH_Z) s = PS_BLK_Z;
        if (s == PS_BLK_ADR && on && c == CH_ZERO) begin
          pr_blank = 1'b1;
          s = PS_IDLE;
          ev = EV_BLANK;
        end
        if (s == PS_BLK_Z && on && c == own) s = PS_BLK_ADR;
        if (c == CH_M) s = PS_HST_HDR;
        if (s == PS_HST_D0 && c == CH_ZERO) begin
          if (!pr_host) begin
            pr_host = 1'b1;
            ev = EV_HOST_ARRIVED;
          end else begin
            pr_link = 1'b1;
            ev = EV_REANNOUNCE;
          end
          s = PS_IDLE;
        end
        if (s == PS_HST_HDR && c == CH_ZERO) s = PS_HST_D0;
        // host frame may have just turned the link on
        on = pr_link;
        if (s == PS_IDLE && on && c == CH_E) s = PS_GON_HDR;
        if (s == PS_GON_D0 && on && c == CH_ZERO) begin
          pr_host = 1'b0;
          pr_seen = 8'd0;
          s = PS_IDLE;
          ev = EV_HOST_GONE;
        end
        if (s == PS_GON_ADR && on && c == CH_ZERO) s = PS_GON_D0;
        if (s == PS_GON_HDR && on && c == own) s = PS_GON_ADR;
        if (s == prev) s = PS_IDLE;
        pr_frame = s;
      end
      OP_JOIN: begin
        pr_link = 1'b1;
        ev = EV_JOINED;
      end
      OP_LEAVE: begin
        pr_link = 1'b0;
        ev = EV_LEFT;
      end
      default: ;
    endcase
    r.ev = ev;
    r.cmd = pr_cmd;
    r.xlate = pr_xlate;
    r.seen = pr_seen;
    return r;
  endfunction

  function automatic void push_word(input logic [1:0] op, input logic [7:0] b);
    link_word_t w;
    w.op = op;
    w.rx = b;
    pending_words.push_back(w);
    n_queued++;
  endfunction

  function automatic logic [7:0] own_byte();
    return {4'd0, node_addr} + CH_ZERO;
  endfunction

  // Replace a frame byte by a random one now and then
  function automatic logic [7:0] garble(input logic [7:0] b, input int pct);
    logic [7:0] r;
    r = 8'($urandom_range(255));
    return ($urandom_range(99) < pct) ? r : b;
  endfunction

  function automatic logic [7:0] stray_byte();
    logic [7:0] r;
    r = 8'($urandom_range(255));
    case ($urandom_range(8))
      0: r = CH_C;
      1: r = CH_X;
      2: r = CH_Z;
      3: r = CH_D;
      4: r = CH_M;
      5: r = CH_E;
      6: r = CH_ZERO;
      7: r = own_byte();
      default: ;
    endcase
    return r;
  endfunction

  task automatic gen_mix(input int n_items, input bit gone_ok);
    int         stop_at;
    int         pick;
    logic [7:0] d;
    stop_at = n_queued + n_items;
    while (n_queued < stop_at) begin
      pick = $urandom_range(99);
      d = 8'($urandom_range(9));
      if (pick < 30) begin
        push_word(OP_BYTE, $urandom_range(1) ? CH_X : CH_C);
        push_word(OP_BYTE, garble(CH_Z, 10));
        push_word(OP_BYTE, garble(own_byte(), 20));
        push_word(OP_BYTE, garble(CH_ZERO + d, 15));
      end else if (pick < 40) begin
        push_word(OP_BYTE, CH_D);
        push_word(OP_BYTE, garble(CH_Z, 10));
        push_word(OP_BYTE, garble(own_byte(), 20));
        push_word(OP_BYTE, garble(CH_ZERO, 15));
      end else if (pick < 50) begin
        push_word(OP_BYTE, CH_M);
        push_word(OP_BYTE, garble(CH_ZERO, 10));
        push_word(OP_BYTE, garble(CH_ZERO, 15));
      end else if (pick < 56 && gone_ok) begin
        push_word(OP_BYTE, CH_E);
        push_word(OP_BYTE, garble(own_byte(), 20));
        push_word(OP_BYTE, garble(CH_ZERO, 15));
      end else if (pick < 66) begin
        push_word(OP_JOIN, 8'($urandom_range(255)));
      end else if (pick < 71) begin
        push_word(OP_LEAVE, 8'($urandom_range(255)));
      end else if (pick < 78) begin
        push_word(OP_UNUSED, 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 3)) push_word(OP_BYTE, stray_byte());
      end
    end
  endtask

  // Long run of clean command frames, enough to wrap the seen counter
  task automatic gen_commands(input int n_cmds);
    logic [7:0] d;
    push_word(OP_JOIN, 8'($urandom_range(255)));
    // any byte that matches nothing returns the frame to idle
    push_word(OP_BYTE, 8'h00);
    repeat (n_cmds) begin
      d = 8'($urandom_range(9));
      if ($urandom_range(19) == 0) push_word(OP_JOIN, 8'($urandom_range(255)));
      push_word(OP_BYTE, $urandom_range(1) ? CH_X : CH_C);
      push_word(OP_BYTE, CH_Z);
      push_word(OP_BYTE, own_byte());
      push_word(OP_BYTE, CH_ZERO + d);
    end
  endtask

  task automatic write_node_address(input logic [3:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    node_addr = v;
  endtask

  // Hold until every word is in and every result is out, then let the pipe empty
  task automatic wait_drained();
    do @(posedge clk); while (n_accepted != n_queued || results_due.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  // Driver
  always @(posedge clk) begin
    link_word_t w;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        results_due.push_back(parse_word(s_axis_tuser, s_axis_tdata));
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= w.op;
          s_axis_tdata <= w.rx;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    parse_result_t exp_r;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result word with nothing expected, actual event %0d data %h",
                   $time, m_axis_tuser, m_axis_tdata);
          n_errors++;
        end else begin
          exp_r = results_due.pop_front();
          if (m_axis_tuser !== exp_r.ev) begin
            $display("%0t: event expected %0d actual %0d", $time, exp_r.ev, m_axis_tuser);
            n_errors++;
          end
          if (m_axis_tdata[3:0] !== exp_r.cmd) begin
            $display("%0t: command_value expected %0d actual %0d",
                     $time, exp_r.cmd, m_axis_tdata[3:0]);
            n_errors++;
          end
          if (m_axis_tdata[4] !== exp_r.xlate) begin
            $display("%0t: translate expected %0d actual %0d",
                     $time, exp_r.xlate, m_axis_tdata[4]);
            n_errors++;
          end
          if (m_axis_tdata[12:5] !== exp_r.seen) begin
            $display("%0t: host_seen_count expected %0d actual %0d",
                     $time, exp_r.seen, m_axis_tdata[12:5]);
            n_errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int phase;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 30;
    recv_stall_pct = 85;

    // Directed frames at the reset address
    push_word(OP_UNUSED, 8'hFF);
    push_word(OP_BYTE, CH_C);          // link still off
    push_word(OP_BYTE, CH_M);
    push_word(OP_BYTE, CH_ZERO);
    push_word(OP_BYTE, CH_ZERO);       // host arrives
    push_word(OP_BYTE, CH_M);
    push_word(OP_BYTE, CH_ZERO);
    push_word(OP_BYTE, CH_ZERO);       // reannounce turns the link on
    push_word(OP_BYTE, CH_X);
    push_word(OP_BYTE, CH_Z);
    push_word(OP_BYTE, own_byte());
    push_word(OP_BYTE, CH_NINE);
    push_word(OP_BYTE, CH_C);
    push_word(OP_BYTE, CH_Z);
    push_word(OP_BYTE, own_byte());
    push_word(OP_BYTE, CH_ZERO);
    push_word(OP_BYTE, CH_D);
    push_word(OP_BYTE, CH_Z);
    push_word(OP_BYTE, own_byte());
    push_word(OP_BYTE, CH_ZERO);
    push_word(OP_BYTE, CH_E);
    push_word(OP_BYTE, own_byte());
    push_word(OP_BYTE, CH_ZERO);
    push_word(OP_LEAVE, 8'h00);
    push_word(OP_JOIN, 8'hFF);
    wait_drained();

    for (phase = 0; phase < 8; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 30;
        recv_stall_pct = 85;
      end else if (phase < 6) begin
        send_idle_pct = 85;
        recv_stall_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_node_address(4'(phase_addr[phase]));
      if (phase == 5 || phase == 7) gen_commands(130);
      else gen_mix(80, phase < 5);
      wait_drained();
    end

    if (n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lcfp_pkg.sv
rtl/lcfp_step.sv
rtl/link_command_frame_parser.sv
test/tb_top.sv
